@@ design/rpn_stack_evaluator_defines.svh @@
// Assertion macros shared by the postfix evaluator RTL.
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a condition at every clock edge outside reset.
`define RPN_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define RPN_ASSERT(lbl, expr, msg)
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/rpn_pkg.sv @@
// Types and constants of the postfix expression evaluator.
`default_nettype none

package rpn_pkg;

  // Status reported with every result item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  // Operator codes of an operator token.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Token kinds.
  localparam logic KIND_NUM = 1'b0;

  // Signed Q16.16 values and their limits.
  typedef logic signed [31:0] q16_t;
  localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q_MIN = 32'sh8000_0000;

  // Shared adder: wide enough for a 33-bit sum and a 33-bit quotient with sign.
  localparam int ALU_W = 34;
  typedef logic signed [ALU_W-1:0] alu_t;

  // Restoring division produces this many quotient bits.
  localparam int DIV_STEPS = 33;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

@@ design/rpn_stack_evaluator.sv @@
// Postfix (RPN) expression evaluator over a bounded stack of Q16.16 values.
//
// Each item is one token: a number is pushed, an operator pops b then a and
// pushes a op b, saturated to the signed 32-bit range. Every item gives one
// result item with status, new top of stack and depth. A small sequencer runs
// all arithmetic through one shared 34-bit add/subtract unit, plus one 32x32
// multiplier. Division runs 33 restoring-division steps in the shared adder;
// a divide by zero or with a quotient too large for the range skips them. The
// stack lives in a memory with one write and one registered read port; the top
// entry is also held in a register. Results wait in an output register, and a
// new item is taken once the sequencer is idle again.
`default_nettype none

`include "rpn_stack_evaluator_defines.svh"

module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_stall,
  input  logic             kind,
  input  rpn_pkg::q16_t    operand_value,
  input  rpn_pkg::op_t     operator_code,
  output logic             res_valid,
  input  logic             res_stall,
  output rpn_pkg::status_t status,
  output rpn_pkg::q16_t    top_value,
  output logic [4:0]       stack_depth,
  output logic             saturated
);
  import rpn_pkg::*;

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_A,
    S_ADDSUB,
    S_MUL,
    S_MUL_RND,
    S_DIV_CHK,
    S_DIV_STEP,
    S_DIV_FIN,
    S_LOAD_TOP,
    S_FINISH
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  q16_t                  top;
  op_t                   op;
  logic                  a_ok;
  q16_t                  a_val;
  q16_t                  b_val;
  status_t               st;
  logic                  sat_r;
  logic signed [63:0]    prod;
  logic [31:0]           rem;
  logic [31:0]           dsr;
  logic [DIV_STEPS-1:0]  nbits;
  logic [DIV_STEPS-1:0]  quo;
  logic                  neg;
  logic [DIV_CW-1:0]     step;

  q16_t                  stack_mem [STACK_DEPTH];
  q16_t                  rd_data;
  logic [IW-1:0]         rd_addr;

  logic                  tok_take;
  logic                  out_free;
  logic                  full;
  alu_t                  alu_x;
  alu_t                  alu_y;
  logic                  alu_sub;
  alu_t                  alu_sum;
  logic                  alu_neg;
  logic                  sat_hi;
  logic                  sat_lo;
  q16_t                  alu_clamp;
  logic signed [47:0]    mul_rnd;
  logic                  mul_hi;
  logic                  mul_lo;
  q16_t                  mul_clamp;
  q16_t                  a_in;
  logic [31:0]           a_mag;
  logic [31:0]           b_mag;
  logic                  wr_en;
  q16_t                  wr_data;
  logic                  wr_sat;

  // Handshake: a token is taken only while the sequencer is idle.
  assign tok_stall = (state != S_IDLE);
  assign tok_take  = tok_valid && !tok_stall;
  assign out_free  = !res_valid || !res_stall;
  assign full      = (count >= DEPTH_C);

  // Read the entry below the top when a token arrives, else the top entry.
  assign rd_addr = (state == S_IDLE) ? IW'(count - CW'(2)) : IW'(count - CW'(1));

  // Operand selection for the shared add/subtract unit.
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b1;
    case (state)
      S_ADDSUB: begin
        alu_x   = ALU_W'(a_val);
        alu_y   = ALU_W'(b_val);
        alu_sub = (op == OP_SUB);
      end
      S_DIV_CHK: begin
        alu_x = ALU_W'(rem);
        alu_y = ALU_W'(dsr);
      end
      S_DIV_STEP: begin
        alu_x = ALU_W'({rem, nbits[DIV_STEPS-1]});
        alu_y = ALU_W'(dsr);
      end
      S_DIV_FIN: begin
        alu_x = neg ? alu_t'(0) : ALU_W'(quo);
        alu_y = neg ? ALU_W'(quo) : alu_t'(0);
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_sum = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);
  assign alu_neg = alu_sum[ALU_W-1];

  // Saturate the adder result to the signed 32-bit range.
  assign sat_hi    = !alu_sum[ALU_W-1] && (alu_sum[ALU_W-2:31] != '0);
  assign sat_lo    = alu_sum[ALU_W-1] && (alu_sum[ALU_W-2:31] != '1);
  assign alu_clamp = sat_hi ? Q_MAX : (sat_lo ? Q_MIN : alu_sum[31:0]);

  // Product rounding: drop 16 fraction bits, round half up, then saturate.
  assign mul_rnd   = prod[63:16] + 48'(prod[15]);
  assign mul_hi    = !mul_rnd[47] && (mul_rnd[46:31] != '0);
  assign mul_lo    = mul_rnd[47] && (mul_rnd[46:31] != '1);
  assign mul_clamp = mul_hi ? Q_MAX : (mul_lo ? Q_MIN : mul_rnd[31:0]);

  // Operand a from memory, and magnitudes for the divider.
  assign a_in  = a_ok ? rd_data : '0;
  assign a_mag = a_in[31] ? 32'(-a_in) : 32'(a_in);
  assign b_mag = b_val[31] ? 32'(-b_val) : 32'(b_val);

  // Push request: a number token or a finished arithmetic result.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = alu_clamp;
    wr_sat  = 1'b0;
    case (state)
      S_IDLE: begin
        wr_en   = tok_take && (kind == KIND_NUM) && !full;
        wr_data = operand_value;
      end
      S_ADDSUB, S_DIV_FIN: begin
        wr_en  = 1'b1;
        wr_sat = sat_hi || sat_lo;
      end
      S_MUL_RND: begin
        wr_en   = 1'b1;
        wr_data = mul_clamp;
        wr_sat  = mul_hi || mul_lo;
      end
      S_DIV_CHK: begin
        // The quotient needs more than 33 bits: it saturates.
        wr_en   = !alu_neg;
        wr_data = neg ? Q_MIN : Q_MAX;
        wr_sat  = 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Stack memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[count[IW-1:0]] <= wr_data;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // Sequencer, stack pointer, datapath registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // A taken result clears the output register unless a new one replaces it.
      if (res_valid && !res_stall && (state != S_FINISH)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (tok_take) begin
            op    <= operator_code;
            if (kind == KIND_NUM) begin
              // A dropped push clears the flag; a real push writes it below.
              if (full) begin
                sat_r <= 1'b0;
              end
              st    <= full ? ST_OVER : ST_OK;
              state <= S_FINISH;
            end else begin
              // Pop b from the top register; a arrives from memory next cycle.
              sat_r <= 1'b0;
              b_val <= (count != '0) ? top : '0;
              a_ok  <= (count >= CW'(2));
              st    <= (count >= CW'(2)) ? ST_OK : ST_UNDER;
              count <= (count >= CW'(2)) ? (count - CW'(2)) : '0;
              state <= S_LOAD_A;
            end
          end
        end

        S_LOAD_A: begin
          a_val <= a_in;
          rem   <= 32'(a_mag[31:17]);
          nbits <= {a_mag[16:0], 16'b0};
          dsr   <= b_mag;
          neg   <= a_in[31] ^ b_val[31];
          quo   <= '0;
          step  <= '0;
          case (op)
            OP_ADD, OP_SUB: begin
              state <= S_ADDSUB;
            end
            OP_MUL: begin
              state <= S_MUL;
            end
            default: begin
              if (b_val == '0) begin
                // Nothing is pushed; the new top is read back from memory.
                if (st == ST_OK) begin
                  st <= ST_DIVZ;
                end
                state <= S_LOAD_TOP;
              end else begin
                state <= S_DIV_CHK;
              end
            end
          endcase
        end

        S_ADDSUB: begin
          state <= S_FINISH;
        end

        S_MUL: begin
          prod  <= 64'(a_val) * 64'(b_val);
          state <= S_MUL_RND;
        end

        S_MUL_RND: begin
          state <= S_FINISH;
        end

        S_DIV_CHK: begin
          state <= alu_neg ? S_DIV_STEP : S_FINISH;
        end

        S_DIV_STEP: begin
          // One restoring step: subtract the divisor when it fits.
          if (!alu_neg) begin
            rem <= alu_sum[31:0];
          end else begin
            rem <= {rem[30:0], nbits[DIV_STEPS-1]};
          end
          quo   <= {quo[DIV_STEPS-2:0], !alu_neg};
          nbits <= nbits << 1;
          step  <= step + DIV_CW'(1);
          if (step == DIV_CW'(DIV_STEPS - 1)) begin
            state <= S_DIV_FIN;
          end
        end

        S_DIV_FIN: begin
          state <= S_FINISH;
        end

        S_LOAD_TOP: begin
          top   <= rd_data;
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (out_free) begin
            res_valid   <= 1'b1;
            status      <= st;
            top_value   <= (count != '0) ? top : '0;
            stack_depth <= 5'(count);
            saturated   <= sat_r;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // A push moves the top register and the count together.
      if (wr_en) begin
        top   <= wr_data;
        count <= count + CW'(1);
        sat_r <= wr_sat;
      end
    end
  end

  // Checks on the stack pointer, the divider and the result path.
  `RPN_ASSERT(a_depth_bound, count <= DEPTH_C, "stack count exceeds depth")
  `RPN_ASSERT_NEXT(a_push_grows, tok_take && (kind == KIND_NUM) && !full, count == $past(count) + CW'(1), "number push did not grow the stack")
  `RPN_ASSERT(a_rem_below_dsr, (state != S_DIV_STEP) || (rem < dsr), "division remainder not below divisor")
  `RPN_ASSERT_NEXT(a_finish_out, (state == S_FINISH) && out_free, res_valid && (state == S_IDLE), "finished item not presented")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the postfix expression evaluator: predicted stack results.
module tb;
  import rpn_pkg::*;

  localparam int   STACK_DEPTH = 16;
  localparam logic KIND_OP     = ~KIND_NUM;
  localparam int   NUM_PHASES  = 3;
  localparam int   PHASE_ITEMS = 484;
  localparam int   DRAIN_WAIT  = 50;

  // Expected contents of one result item.
  typedef struct {
    status_t    status;
    q16_t       top;
    logic [4:0] depth;
    logic       sat;
  } token_result_t;

  // Tracks the evaluator stack and holds the results that tokens will produce.
  class rpn_tracker;
    q16_t          stack_mem[STACK_DEPTH];
    int            count;
    token_result_t pending[$];
    int            errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    function bit idle();
      return pending.size() == 0;
    endfunction

    // Clamps a wide result to the signed 32-bit range and notes the clamp.
    function q16_t saturate(input longint v, inout bit sat);
      if (v > longint'(Q_MAX)) begin
        sat = 1'b1;
        return Q_MAX;
      end
      if (v < longint'(Q_MIN)) begin
        sat = 1'b1;
        return Q_MIN;
      end
      return q16_t'(v);
    endfunction

    // An empty stack reads as zero and flags an underflow.
    function q16_t pop(inout bit under);
      if (count == 0) begin
        under = 1'b1;
        return '0;
      end
      count--;
      return stack_mem[count];
    endfunction

    // Applies one accepted token to the stack and queues its result item.
    function void accept_token(input logic k, input q16_t v, input op_t op);
      token_result_t res;
      bit            under;
      bit            sat;
      bit            push;
      q16_t          a;
      q16_t          b;
      q16_t          r;
      longint        wide;
      under = 1'b0;
      sat   = 1'b0;
      push  = 1'b1;
      r     = '0;
      res.status = ST_OK;
      if (k == KIND_NUM) begin
        if (count >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_mem[count] = v;
          count++;
        end
      end else begin
        b = pop(under);
        a = pop(under);
        case (op)
          OP_ADD: r = saturate(longint'(a) + longint'(b), sat);
          OP_SUB: r = saturate(longint'(a) - longint'(b), sat);
          OP_MUL: begin
            // Round to nearest with ties toward plus infinity, then floor.
            wide = longint'(a) * longint'(b) + 64'sd32768;
            r = saturate(wide >>> 16, sat);
          end
          default: begin
            if (b == 0) begin
              push = 1'b0;
            end else begin
              r = saturate((longint'(a) * 64'sd65536) / longint'(b), sat);
            end
          end
        endcase
        if (under) begin
          res.status = ST_UNDER;
        end else if (!push) begin
          res.status = ST_DIVZ;
        end
        if (push && count < STACK_DEPTH) begin
          stack_mem[count] = r;
          count++;
        end
      end
      res.top   = (count > 0) ? stack_mem[count-1] : '0;
      res.depth = 5'(count);
      res.sat   = sat;
      pending.push_back(res);
    endfunction

    // Compares one result item with the oldest expected one.
    function void check_result(input status_t st, input q16_t top, input logic [4:0] dep,
                               input logic sat);
      token_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result item with none expected (status %0d top %h depth %0d)",
                 $time, st, top, dep);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (st !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, st);
        errors++;
      end
      if (top !== want.top) begin
        $display("%0t: top_value expected %h got %h", $time, want.top, top);
        errors++;
      end
      if (dep !== want.depth) begin
        $display("%0t: stack_depth expected %0d got %0d", $time, want.depth, dep);
        errors++;
      end
      if (sat !== want.sat) begin
        $display("%0t: saturated expected %0d got %0d", $time, want.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       tok_valid;
  logic       tok_stall;
  logic       kind;
  q16_t       operand_value;
  op_t        operator_code;
  logic       res_valid;
  logic       res_stall;
  status_t    status;
  q16_t       top_value;
  logic [4:0] stack_depth;
  logic       saturated;

  int         send_idle_pct;
  int         recv_stall_pct;
  rpn_tracker tracker;

  rpn_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall),
    .kind         (kind),
    .operand_value(operand_value),
    .operator_code(operator_code),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .status       (status),
    .top_value    (top_value),
    .stack_depth  (stack_depth),
    .saturated    (saturated)
  );

  always #4 clk = ~clk;

  // Result side: random stall and a check of every accepted result item.
  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall === 1'b0) begin
      tracker.check_result(status, top_value, stack_depth, saturated);
    end
    res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Presents one token, with a random gap before it, and waits for acceptance.
  task automatic send_token(input logic k, input q16_t v, input op_t op);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      tok_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    tok_valid     <= 1'b1;
    kind          <= k;
    operand_value <= v;
    operator_code <= op;
    @(posedge clk);
    while (tok_stall) @(posedge clk);
    tracker.accept_token(k, v, op);
  endtask

  // Holds the token side idle until every expected result item has come.
  task automatic drain_results();
    tok_valid <= 1'b0;
    do @(posedge clk); while (!tracker.idle());
  endtask

  // Number tokens favor extremes, zero and small values over plain random bits.
  function automatic q16_t pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3, 4:    return q16_t'(($urandom_range(0, 20) - 10) <<< 16);
      5:       return q16_t'(int'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      default: return q16_t'($urandom);
    endcase
  endfunction

  // Mostly well-formed streams: pushes when shallow, operators when deep, some noise.
  task automatic random_token();
    int   r;
    logic k;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      k = logic'($urandom_range(0, 1));
    end else if (tracker.count < 2) begin
      k = KIND_NUM;
    end else if (tracker.count >= STACK_DEPTH) begin
      k = (r < 15) ? KIND_NUM : KIND_OP;
    end else begin
      k = ($urandom_range(0, STACK_DEPTH) >= tracker.count) ? KIND_NUM : KIND_OP;
    end
    send_token(k, pick_value(), op_t'($urandom_range(0, 3)));
  endtask

  initial begin
    q16_t fill[STACK_DEPTH];
    fill = '{Q_MAX, Q_MIN, 32'sh0001_0000, 32'sh0000_8000, 32'shFFFF_8000, 32'sh0,
             32'sh0002_0000, 32'sh0003_0000, 32'shFFFE_0000, 32'sh0000_0001,
             32'shFFFF_FFFF, Q_MAX, Q_MAX, Q_MIN, Q_MIN, 32'shFFFF_FFFF};
    tracker        = new();
    clk            = 1'b0;
    rst            = 1'b1;
    tok_valid      = 1'b0;
    kind           = KIND_NUM;
    operand_value  = '0;
    operator_code  = OP_ADD;
    res_stall      = 1'b0;
    send_idle_pct  = 29;
    recv_stall_pct = 72;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Operators on an empty stack underflow; a divide with one operand missing
    // reports the underflow rather than the zero divisor.
    send_token(KIND_OP, q16_t'($urandom), OP_ADD);
    send_token(KIND_OP, q16_t'($urandom), OP_DIV);

    // Fill the stack with extremes, then push once more onto the full stack.
    foreach (fill[i]) send_token(KIND_NUM, fill[i], op_t'($urandom_range(0, 3)));
    send_token(KIND_NUM, Q_MAX, OP_MUL);

    // Every operator saturating: MIN / tiny negative, MIN * MAX, MAX - MIN, MAX + MAX.
    send_token(KIND_OP, Q_MIN, OP_DIV);
    send_token(KIND_OP, '0, OP_MUL);
    send_token(KIND_OP, Q_MAX, OP_SUB);
    send_token(KIND_OP, '0, OP_ADD);

    // Divide by zero without underflow.
    send_token(KIND_NUM, '0, OP_DIV);
    send_token(KIND_OP, Q_MAX, OP_DIV);

    // A product that is an exact tie rounds toward plus infinity.
    send_token(KIND_NUM, 32'sh0000_8000, OP_SUB);
    send_token(KIND_OP, Q_MIN, OP_MUL);
    drain_results();

    // Random phases with swapped idle rates, then full throughput.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 29;
          recv_stall_pct = 72;
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 29;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 199) == 0) drain_results();
        random_token();
      end
      drain_results();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0 && tracker.idle()) begin
      $display("** rpn_stack_evaluator: PASSED **");
    end else begin
      $display("** rpn_stack_evaluator: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8000000;
    $display("** rpn_stack_evaluator: FAILED **");
    $finish;
  end

endmodule
